@@ design/utt_pkg.sv @@
// shared types and constants of the utf-8 to utf-16 transcoder
`timescale 1ns / 1ps

package utt_pkg;

    localparam int DataByteWidth = 8;
    localparam int CodeUnitWidth = 21;
    localparam int MDataWidth    = 24;
    localparam int MUserWidth    = 2;

    // sequence class codes
    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_TWO   = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR  = 2'd3;

    // unit mode codes
    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] MIN_FOUR    = 21'h010000;
    localparam logic [20:0] MAX_POINT   = 21'h10ffff;
    localparam logic [20:0] SURR_LOW    = 21'h00d800;
    localparam logic [20:0] SURR_HIGH   = 21'h00dfff;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

    typedef struct packed {
        logic [CodeUnitWidth-1:0] code_unit;
        logic                     failed;
        logic                     string_done;
        logic                     run_last;
    } utt_result_t;

    typedef struct packed {
        logic [1:0]  count;
        utt_result_t first;
        utt_result_t second;
    } utt_push_t;

endpackage

@@ design/utf8_to_utf16_transcoder_unit.sv @@
// top level of the utf-8 to utf-16 transcoder
//
//  channel | ports                   | content
//  --------+-------------------------+-------------------------------------------
//  s_      | tvalid tready tdata tlast | tdata: data_byte; tlast: string_last
//  m_      | tvalid tready tdata tuser tlast | tdata: code_unit; tuser: failed,
//          |                         |   string_done; tlast: run_last
//  cfg_    | wr_en wr_data           | unit_mode
//
// one byte is taken per cycle while s_tready is high; its results sit in the output register the next cycle
// a byte that completes a supplementary code point in 16-bit mode gives two
// transfers, and the input holds while the second one leaves
// the input stalls while the result register is still held by m_tready low
// reset clears the sequence state, the discard flag and unit_mode to 16-bit
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [utt_pkg::DataByteWidth-1:0] s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [utt_pkg::MDataWidth-1:0]    m_tdata,   // [20:0] code_unit, [23:21] zero
    output logic [utt_pkg::MUserWidth-1:0]    m_tuser,   // [0] failed, [1] string_done
    output logic                              m_tlast
);
    import utt_pkg::*;

    logic        accept;
    utt_push_t   push;
    utt_result_t out_res;

    assign accept = s_tvalid && s_tready;

    utt_decoder u_decoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (accept),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .push        (push)
    );

    utt_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (accept),
        .push       (push),
        .can_push   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {3'd0, out_res.code_unit};
    assign m_tuser = {out_res.string_done, out_res.failed};
    assign m_tlast = out_res.run_last;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && m_tlast))
        else $error("failed result carries data");

endmodule

@@ design/utt_decoder.sv @@
// utf-8 sequence decoder: state registers and per-byte result logic
`timescale 1ns / 1ps

module utt_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,
    input  logic                                 in_accept,
    input  logic [utt_pkg::DataByteWidth-1:0]    in_byte,
    input  logic                                 in_last,
    output utt_pkg::utt_push_t                   push
);
    import utt_pkg::*;

    logic        unit_mode_reg;
    logic [1:0]  pending_reg, pending_next;
    logic [20:0] partial_reg, partial_next;
    logic [1:0]  class_reg, class_next;
    logic        discard_reg, discard_next;

    logic        err, complete;
    logic [20:0] cp, shifted, minimum;
    logic [19:0] offset;
    utt_result_t fail_res;

    always_comb begin
        shifted = {partial_reg[14:0], in_byte[5:0]};
        case (class_reg)
            CLASS_TWO:   minimum = MIN_TWO;
            CLASS_THREE: minimum = MIN_THREE;
            default:     minimum = MIN_FOUR;
        endcase
    end

    always_comb begin
        err          = 1'b0;
        complete     = 1'b0;
        cp           = '0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        class_next   = class_reg;
        discard_next = discard_reg;

        if (pending_reg == 2'd0) begin
            if (in_byte[7] == 1'b0) begin
                cp       = {13'd0, in_byte};
                complete = 1'b1;
            end else if (in_byte[7:5] == 3'b110) begin
                partial_next = {16'd0, in_byte[4:0]};
                pending_next = 2'd1;
                class_next   = CLASS_TWO;
            end else if (in_byte[7:4] == 4'b1110) begin
                partial_next = {17'd0, in_byte[3:0]};
                pending_next = 2'd2;
                class_next   = CLASS_THREE;
            end else if (in_byte[7:3] == 5'b11110) begin
                partial_next = {18'd0, in_byte[2:0]};
                pending_next = 2'd3;
                class_next   = CLASS_FOUR;
            end else begin
                err = 1'b1;
            end
        end else if (in_byte[7:6] != 2'b10) begin
            err = 1'b1;
        end else begin
            partial_next = shifted;
            pending_next = pending_reg - 2'd1;
            if (pending_reg == 2'd1) begin
                cp = shifted;
                if (shifted < minimum || shifted > MAX_POINT ||
                    (shifted >= SURR_LOW && shifted <= SURR_HIGH)) begin
                    err = 1'b1;
                end else begin
                    complete = 1'b1;
                end
                partial_next = '0;
                class_next   = CLASS_NONE;
            end
        end

        // a last byte with the sequence still open is a truncation error
        if (!err && !complete && in_last) begin
            err = 1'b1;
        end

        if (err || in_last) begin
            pending_next = 2'd0;
            partial_next = '0;
            class_next   = CLASS_NONE;
            discard_next = err && !in_last;
        end

        if (discard_reg) begin
            err          = in_last;
            complete     = 1'b0;
            pending_next = 2'd0;
            partial_next = '0;
            class_next   = CLASS_NONE;
            discard_next = !in_last;
        end
    end

    always_comb begin
        offset   = cp[19:0] - MIN_FOUR[19:0];
        fail_res = '{code_unit: '0, failed: 1'b1, string_done: in_last, run_last: 1'b1};
        push     = '0;
        if (err) begin
            push.count = 2'd1;
            push.first = fail_res;
        end else if (complete) begin
            if (unit_mode_reg == MODE_UTF16 && cp[20:16] != 5'd0) begin
                push.count  = 2'd2;
                push.first  = '{code_unit: {5'd0, HI_SURR_TAG, offset[19:10]},
                                failed: 1'b0, string_done: 1'b0, run_last: 1'b0};
                push.second = '{code_unit: {5'd0, LO_SURR_TAG, offset[9:0]},
                                failed: 1'b0, string_done: in_last, run_last: 1'b1};
            end else begin
                push.count = 2'd1;
                push.first = '{code_unit: cp, failed: 1'b0, string_done: in_last,
                               run_last: 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_mode_reg <= MODE_UTF16;
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            class_reg     <= CLASS_NONE;
            discard_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unit_mode_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                class_reg   <= class_next;
                discard_reg <= discard_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        discard_reg |-> (pending_reg == 2'd0 && class_reg == CLASS_NONE))
        else $error("discarding with an open sequence");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_last) |=> (pending_reg == 2'd0 && !discard_reg))
        else $error("state not cleared after string end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg == 2'd0) == (class_reg == CLASS_NONE))
        else $error("pending count and class disagree");

endmodule

@@ design/utt_out_buf.sv @@
// two-entry result register that holds a surrogate pair
`timescale 1ns / 1ps

module utt_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  utt_pkg::utt_push_t   push,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output utt_pkg::utt_result_t out_data
);
    import utt_pkg::*;

    logic [1:0]  cnt_reg;
    utt_result_t head_reg, tail_reg;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;
    // room for two results once the head leaves
    assign can_push  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (push_valid) begin
            cnt_reg <= push.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            head_reg <= push.first;
            tail_reg <= push.second;
        end else if (pop) begin
            head_reg <= tail_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer overfilled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push_valid)
        else $error("push into a full result buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && pop) |=> (cnt_reg == 2'd1 && out_data.run_last))
        else $error("second half of pair lost");

endmodule

@@ verif/utt_stream_checker.sv @@
// stream checker for the utf-8 transcoder: predicts results per accepted byte and compares them
`timescale 1ns / 1ps

module utt_stream_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [utt_pkg::DataByteWidth-1:0] s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [utt_pkg::MDataWidth-1:0]    m_tdata,
    input  logic [utt_pkg::MUserWidth-1:0]    m_tuser,
    input  logic                              m_tlast,
    output int                                fail_count,
    output int                                outstanding
);
    import utt_pkg::*;

    utt_result_t expected_units[$];

    logic        mode_reg;
    logic [1:0]  pend_cnt;
    logic [20:0] point_acc;
    logic [1:0]  seq_class;
    logic        dropping;
    int          errors;

    task automatic report_mismatch(input string msg);
        if (errors < 30) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        errors++;
    endtask

    task automatic clear_sequence();
        pend_cnt  = 2'd0;
        point_acc = '0;
        seq_class = CLASS_NONE;
        dropping  = 1'b0;
    endtask

    task automatic push_unit(input logic [20:0] cu, input logic fl, input logic dn,
                             input logic rl);
        utt_result_t r;
        r.code_unit   = cu;
        r.failed      = fl;
        r.string_done = dn;
        r.run_last    = rl;
        expected_units = {expected_units, r};
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic        err;
        logic        complete;
        logic [20:0] cp;
        logic [20:0] floor_val;
        logic [20:0] offs;
        err      = 1'b0;
        complete = 1'b0;
        cp       = '0;
        if (dropping) begin
            if (last) begin
                push_unit('0, 1'b1, 1'b1, 1'b1);
                clear_sequence();
            end
            return;
        end
        if (pend_cnt == 2'd0) begin
            if (b[7] == 1'b0) begin
                cp       = {13'd0, b};
                complete = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                point_acc = {16'd0, b[4:0]};
                pend_cnt  = 2'd1;
                seq_class = CLASS_TWO;
            end else if (b[7:4] == 4'b1110) begin
                point_acc = {17'd0, b[3:0]};
                pend_cnt  = 2'd2;
                seq_class = CLASS_THREE;
            end else if (b[7:3] == 5'b11110) begin
                point_acc = {18'd0, b[2:0]};
                pend_cnt  = 2'd3;
                seq_class = CLASS_FOUR;
            end else begin
                err = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            // a non-continuation byte is not reused as a new lead
            err = 1'b1;
        end else begin
            point_acc = {point_acc[14:0], b[5:0]};
            pend_cnt  = pend_cnt - 2'd1;
            if (pend_cnt == 2'd0) begin
                case (seq_class)
                    CLASS_TWO:   floor_val = MIN_TWO;
                    CLASS_THREE: floor_val = MIN_THREE;
                    default:     floor_val = MIN_FOUR;
                endcase
                cp = point_acc;
                if (cp < floor_val || cp > MAX_POINT || (cp >= SURR_LOW && cp <= SURR_HIGH))
                    err = 1'b1;
                else
                    complete = 1'b1;
                point_acc = '0;
                seq_class = CLASS_NONE;
            end
        end

        if (!err && !complete) begin
            if (!last)
                return;
            err = 1'b1;  // string ends mid-sequence
        end

        if (err) begin
            push_unit('0, 1'b1, last, 1'b1);
            clear_sequence();
            dropping = !last;
            return;
        end

        if (mode_reg == MODE_UTF16 && cp > 21'h00ffff) begin
            offs = cp - MIN_FOUR;
            push_unit({5'd0, HI_SURR_TAG, offs[19:10]}, 1'b0, 1'b0, 1'b0);
            push_unit({5'd0, LO_SURR_TAG, offs[9:0]}, 1'b0, last, 1'b1);
        end else begin
            push_unit(cp, 1'b0, last, 1'b1);
        end
    endtask

    task automatic check_transfer();
        utt_result_t e;
        if (expected_units.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: tdata %h tuser %b tlast %b",
                                      m_tdata, m_tuser, m_tlast));
            return;
        end
        e = expected_units.pop_front();
        if (m_tdata !== {3'b000, e.code_unit})
            report_mismatch($sformatf("code_unit got %h exp %h", m_tdata, e.code_unit));
        if (m_tuser[0] !== e.failed)
            report_mismatch($sformatf("failed got %b exp %b", m_tuser[0], e.failed));
        if (m_tuser[1] !== e.string_done)
            report_mismatch($sformatf("string_done got %b exp %b", m_tuser[1], e.string_done));
        if (m_tlast !== e.run_last)
            report_mismatch($sformatf("run_last got %b exp %b", m_tlast, e.run_last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg = MODE_UTF16;
            clear_sequence();
            expected_units.delete();
        end else begin
            // results are registered, so a result never leaves with its own byte; outputs go first
            if (m_tvalid && m_tready)
                check_transfer();
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (cfg_wr_en)
                mode_reg = cfg_wr_data;
        end
        outstanding <= expected_units.size();
        fail_count  <= errors;
    end

endmodule

@@ verif/testbench.sv @@
// top of the transcoder testbench: clock, reset, byte strings, mode writes and the verdict
`timescale 1ns / 1ps

module testbench;
    import utt_pkg::*;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic                     cfg_wr_data = 1'b0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [DataByteWidth-1:0] s_tdata     = '0;
    logic                     s_tlast     = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [MDataWidth-1:0]    m_tdata;
    logic [MUserWidth-1:0]    m_tuser;
    logic                     m_tlast;
    int                       fail_count;
    int                       outstanding;

    logic                     no_idle  = 1'b0;
    logic                     hold_req = 1'b0;
    logic [7:0]               str_bytes[$];

    always #2 aclk = ~aclk;

    utf8_to_utf16_transcoder_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    utt_stream_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    task automatic append_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_string();
        int n;
        n = str_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(str_bytes[i], i == n - 1);
        str_bytes.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        // bytes with no result may still sit in the pipe
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // len may exceed the shortest form, which makes an overlong encoding
    task automatic push_point(input logic [20:0] cp, input int len);
        case (len)
            1: append_byte({1'b0, cp[6:0]});
            2: begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3: begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default: begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_good_point();
        int          len;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        len = $urandom_range(1, 4);
        case (len)
            1:       begin lo = 21'h0;   hi = 21'h7f;     end
            2:       begin lo = MIN_TWO;   hi = 21'h7ff;  end
            3:       begin lo = MIN_THREE; hi = 21'hffff; end
            default: begin lo = MIN_FOUR;  hi = MAX_POINT; end
        endcase
        if ($urandom_range(0, 7) == 0)
            cp = $urandom_range(0, 1) ? lo : hi;
        else
            cp = 21'($urandom_range(lo, hi));
        if (len == 3 && cp >= SURR_LOW && cp <= SURR_HIGH)
            cp = cp - 21'h001000;
        push_point(cp, len);
    endtask

    task automatic add_bad_point();
        int len;
        case ($urandom_range(0, 5))
            0: append_byte(8'($urandom_range(0, 255)));
            1: begin
                // overlong
                len = $urandom_range(2, 4);
                case (len)
                    2:       push_point(21'($urandom_range(0, 21'h7f)), 2);
                    3:       push_point(21'($urandom_range(0, 21'h7ff)), 3);
                    default: push_point(21'($urandom_range(0, 21'hffff)), 4);
                endcase
            end
            2: push_point(21'($urandom_range(SURR_LOW, SURR_HIGH)), 3);
            3: push_point(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
            4: begin
                // truncated sequence
                len = $urandom_range(2, 4);
                push_point(21'($urandom), len);
                repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
            end
            default: append_byte(8'($urandom_range(8'h80, 8'hbf)));
        endcase
    endtask

    task automatic add_random_string();
        int npoints;
        int bad_at;
        npoints = $urandom_range(1, 6);
        bad_at  = ($urandom_range(0, 99) < 30) ? $urandom_range(0, npoints - 1) : -1;
        for (int i = 0; i < npoints; i++) begin
            if (i == bad_at)
                add_bad_point();
            else
                add_good_point();
        end
    endtask

    task automatic run_phase(input int nbytes, input logic pressure);
        int sent;
        sent = 0;
        while (sent < nbytes) begin
            add_random_string();
            sent += str_bytes.size();
            send_string();
            if (pressure && sent > 30 && sent < 60)
                hold_req = 1'b1;
        end
    endtask

    // receiver
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // valid extremes of the one- and two-byte classes and the upper ends of the others, ending on a surrogate pair
        str_bytes = '{8'h00, 8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf, 8'hef, 8'hbf, 8'hbf,
                      8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_string();
        // overlong from a c0 lead, then the rest of the string is dropped
        str_bytes = '{8'hc0, 8'h80, 8'h41};
        send_string();
        str_bytes = '{8'h80};
        send_string();
        str_bytes = '{8'hff};
        send_string();
        // lead interrupted by a plain byte on the last transfer
        str_bytes = '{8'he1, 8'h41};
        send_string();
        str_bytes = '{8'he0};
        send_string();
        str_bytes = '{8'hed, 8'ha0, 8'h80};
        send_string();
        str_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
        send_string();

        write_mode(MODE_UTF32);
        str_bytes = '{8'hf0, 8'h90, 8'h80, 8'h80};
        send_string();

        for (int p = 0; p < 6; p++) begin
            write_mode((p % 2 == 0) ? MODE_UTF16 : MODE_UTF32);
            no_idle = (p == 2);
            run_phase(145, p == 3);
        end
        no_idle = 1'b0;
        wait_drained();

        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
